/* sv/utf8_to_utf16_offset_mapper_defines.svh */
// Assertion helpers for the UTF-8 to UTF-16 offset mapper.
`ifndef UTF8_TO_UTF16_OFFSET_MAPPER_DEFINES_SVH
`define UTF8_TO_UTF16_OFFSET_MAPPER_DEFINES_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define U8U16_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define U8U16_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/u8u16_pkg.sv */
`default_nettype none
package u8u16_pkg;

   localparam int OFFSET_BITS_DEFAULT = 16;

   // result kinds
   localparam logic [1:0] KIND_UNIT = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // allowed range of the second byte of a sequence
   localparam logic [1:0] SBC_NORMAL = 2'd0; // 80..BF
   localparam logic [1:0] SBC_E0     = 2'd1; // A0..BF
   localparam logic [1:0] SBC_LOW    = 2'd2; // 80..9F, or 80..8F for length 4
   localparam logic [1:0] SBC_F0     = 2'd3; // 90..BF

   localparam logic [20:0] SUPP_BASE    = 21'h10000;
   localparam logic [15:0] SURR_HI_BASE = 16'hD800;
   localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
   localparam logic [9:0]  SURR_MASK    = 10'h3FF;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] unit_value;
      logic [15:0] source_offset;
      logic [2:0]  sequence_length;
      logic [15:0] unit_index;
      logic        last_of_run;
   } rsp_type;

endpackage
`default_nettype wire

/* sv/utf8_to_utf16_offset_mapper.sv */
// Channel  | Direction | Ports                                 | Carries
// request  | in        | req_valid, req_ready, req_payload     | one UTF-8 byte + final flag
// response | out       | rsp_valid, rsp_ready, rsp_payload     | UTF-16 unit, end totals or error
//
// Each byte is decoded in the cycle it is accepted; its 0..3 results go into a
// four-entry result queue whose head drives the response port.
// One byte per cycle while each byte yields at most one result and the response
// side keeps up; a byte giving a surrogate pair plus end totals holds off later bytes
// until the single response port, draining the queue one entry a cycle, has emptied it to one result.
// Requests are taken while the queue holds at most one result.
// Synchronous active-high reset clears decoder state, counters and the queue.
`default_nettype none
`include "utf8_to_utf16_offset_mapper_defines.svh"
module utf8_to_utf16_offset_mapper #(
   parameter int OFFSET_BITS = u8u16_pkg::OFFSET_BITS_DEFAULT
) (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic req_valid,
   output                     logic req_ready,
   input  wire u8u16_pkg::req_type req_payload,
   output                     logic rsp_valid,
   input  wire                logic rsp_ready,
   output      u8u16_pkg::rsp_type rsp_payload
);
   import u8u16_pkg::*;

   localparam int QDEPTH = 4;

   // decoder state
   logic [1:0]             bytes_remaining_ff, bytes_remaining_in;
   logic [2:0]             current_length_ff, current_length_in;
   logic [20:0]            code_accumulator_ff, code_accumulator_in;
   logic [1:0]             second_byte_class_ff, second_byte_class_in;
   logic [OFFSET_BITS-1:0] byte_counter_ff, byte_counter_in;
   logic [OFFSET_BITS-1:0] sequence_start_ff, sequence_start_in;
   logic [OFFSET_BITS-1:0] unit_counter_ff, unit_counter_in;
   logic                   discarding_ff, discarding_in;

   // result queue, entry 0 is the head
   rsp_type    q_ff [QDEPTH];
   rsp_type    q_in [QDEPTH];
   logic [2:0] cnt_ff, cnt_in;

   rsp_type    res [QDEPTH];
   logic [1:0] n_new;

   logic push, pop;
   logic [2:0] base;

   assign req_ready   = (cnt_ff <= 3'd1);
   assign rsp_valid   = (cnt_ff != 3'd0);
   assign rsp_payload = q_ff[0];
   assign push        = req_valid && req_ready;
   assign pop         = rsp_valid && rsp_ready;

   // decode one byte
   always_comb begin
      logic [7:0]             b;
      logic                   fin, err, done, ok, is_second;
      logic [20:0]            cp, adj;
      logic [OFFSET_BITS-1:0] bc1, uc1, uc2;
      logic [1:0]             k;
      b   = req_payload.text_byte;
      fin = req_payload.final_byte;
      err = 1'b0;
      done = 1'b0;
      ok  = 1'b0;
      is_second = 1'b0;
      k   = 2'd0;
      cp  = '0;
      adj = '0;
      bc1 = byte_counter_ff + OFFSET_BITS'(1);
      uc1 = unit_counter_ff + OFFSET_BITS'(1);
      uc2 = unit_counter_ff + OFFSET_BITS'(2);

      bytes_remaining_in   = bytes_remaining_ff;
      current_length_in    = current_length_ff;
      code_accumulator_in  = code_accumulator_ff;
      second_byte_class_in = second_byte_class_ff;
      byte_counter_in      = byte_counter_ff;
      sequence_start_in    = sequence_start_ff;
      unit_counter_in      = unit_counter_ff;
      discarding_in        = discarding_ff;
      for (int i = 0; i < QDEPTH; i++) begin
         res[i] = '0;
      end

      if (discarding_ff) begin
         byte_counter_in = bc1;
      end else begin
         if (bytes_remaining_ff == 2'd0) begin
            sequence_start_in    = byte_counter_ff;
            second_byte_class_in = SBC_NORMAL;
            if (b < 8'h80) begin
               code_accumulator_in = {13'd0, b};
               current_length_in   = 3'd1;
               done                = 1'b1;
            end else if (b >= 8'hC2 && b <= 8'hDF) begin
               code_accumulator_in = {16'd0, b[4:0]};
               current_length_in   = 3'd2;
               bytes_remaining_in  = 2'd1;
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
               code_accumulator_in = {17'd0, b[3:0]};
               current_length_in   = 3'd3;
               bytes_remaining_in  = 2'd2;
               if (b == 8'hE0) second_byte_class_in = SBC_E0;
               else if (b == 8'hED) second_byte_class_in = SBC_LOW;
            end else if (b >= 8'hF0 && b <= 8'hF4) begin
               code_accumulator_in = {18'd0, b[2:0]};
               current_length_in   = 3'd4;
               bytes_remaining_in  = 2'd3;
               if (b == 8'hF0) second_byte_class_in = SBC_F0;
               else if (b == 8'hF4) second_byte_class_in = SBC_LOW;
            end else begin
               err = 1'b1;
            end
         end else begin
            is_second = (({1'b0, bytes_remaining_ff} + 3'd1) == current_length_ff);
            if (is_second) begin
               case (second_byte_class_ff)
                  SBC_E0:  ok = (b >= 8'hA0 && b <= 8'hBF);
                  SBC_LOW: ok = (b >= 8'h80) &&
                                (b <= ((current_length_ff == 3'd4) ? 8'h8F : 8'h9F));
                  SBC_F0:  ok = (b >= 8'h90 && b <= 8'hBF);
                  default: ok = (b >= 8'h80 && b <= 8'hBF);
               endcase
            end else begin
               ok = (b >= 8'h80 && b <= 8'hBF);
            end
            if (ok) begin
               code_accumulator_in = {code_accumulator_ff[14:0], b[5:0]};
               bytes_remaining_in  = bytes_remaining_ff - 2'd1;
               done                = (bytes_remaining_ff == 2'd1);
            end else begin
               err = 1'b1;
            end
         end

         if (!err && !done && fin) err = 1'b1;

         cp  = code_accumulator_in;
         adj = cp - SUPP_BASE;

         if (err) begin
            res[0].kind          = KIND_ERR;
            res[0].source_offset = 16'(sequence_start_in);
            res[0].last_of_run   = 1'b1;
            k                    = 2'd1;
            discarding_in        = 1'b1;
            bytes_remaining_in   = 2'd0;
            byte_counter_in      = bc1;
         end else begin
            if (done) begin
               res[0].kind            = KIND_UNIT;
               res[0].source_offset   = 16'(sequence_start_in);
               res[0].sequence_length = current_length_in;
               res[0].unit_index      = 16'(unit_counter_ff);
               if (cp < SUPP_BASE) begin
                  res[0].unit_value = cp[15:0];
                  unit_counter_in   = uc1;
                  k                 = 2'd1;
               end else begin
                  res[0].unit_value      = SURR_HI_BASE + {5'd0, adj[20:10]};
                  res[1].kind            = KIND_UNIT;
                  res[1].unit_value      = SURR_LO_BASE + {6'd0, adj[9:0] & SURR_MASK};
                  res[1].source_offset   = 16'(sequence_start_in);
                  res[1].sequence_length = current_length_in;
                  res[1].unit_index      = 16'(uc1);
                  unit_counter_in        = uc2;
                  k                      = 2'd2;
               end
            end
            byte_counter_in = bc1;
            if (fin) begin
               res[k].kind          = KIND_END;
               res[k].source_offset = 16'(bc1);
               res[k].unit_index    = 16'(unit_counter_in);
               k                    = k + 2'd1;
            end
            if (k != 2'd0) res[k - 2'd1].last_of_run = 1'b1;
         end
      end

      // final byte always returns to the reset state
      if (fin) begin
         bytes_remaining_in   = '0;
         current_length_in    = '0;
         code_accumulator_in  = '0;
         second_byte_class_in = SBC_NORMAL;
         byte_counter_in      = '0;
         sequence_start_in    = '0;
         unit_counter_in      = '0;
         discarding_in        = 1'b0;
      end
      n_new = k;
   end

   // queue: shift on pop, append new results behind what remains
   always_comb begin
      logic [2:0] idx;
      base = cnt_ff - {2'd0, pop};
      for (int i = 0; i < QDEPTH; i++) begin
         q_in[i] = q_ff[i];
      end
      if (pop) begin
         for (int i = 0; i < QDEPTH - 1; i++) begin
            q_in[i] = q_ff[i + 1];
         end
      end
      for (int i = 0; i < QDEPTH; i++) begin
         idx = 3'(i) - base;
         if (push && 3'(i) >= base && idx < {1'b0, n_new}) begin
            q_in[i] = res[idx[1:0]];
         end
      end
      cnt_in = push ? base + {1'b0, n_new} : base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_remaining_ff   <= '0;
         current_length_ff    <= '0;
         code_accumulator_ff  <= '0;
         second_byte_class_ff <= SBC_NORMAL;
         byte_counter_ff      <= '0;
         sequence_start_ff    <= '0;
         unit_counter_ff      <= '0;
         discarding_ff        <= 1'b0;
         cnt_ff               <= '0;
      end else begin
         if (push) begin
            bytes_remaining_ff   <= bytes_remaining_in;
            current_length_ff    <= current_length_in;
            code_accumulator_ff  <= code_accumulator_in;
            second_byte_class_ff <= second_byte_class_in;
            byte_counter_ff      <= byte_counter_in;
            sequence_start_ff    <= sequence_start_in;
            unit_counter_ff      <= unit_counter_in;
            discarding_ff        <= discarding_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   `U8U16_ASSERT_NEXT(a_final_clears, push && req_payload.final_byte,
      byte_counter_ff == '0 && unit_counter_ff == '0 && !discarding_ff,
      "final byte did not restore idle decoder state")
   `U8U16_ASSERT_NOW(a_final_answers, push && req_payload.final_byte && !discarding_ff,
      n_new != 2'd0, "final byte outside discard produced no result")
   `U8U16_ASSERT_NEXT(a_drain_only, pop && !push, cnt_ff == $past(cnt_ff) - 3'd1,
      "queue count wrong after a lone pop")

endmodule
`default_nettype wire
